// File: src/psar_pkg.sv
// ----------------------------------------------------------------------------
// psar_pkg
// Shared types and constants for the parabolic stop-and-reverse tracker.
// ----------------------------------------------------------------------------
package psar_pkg;

    localparam int PRICE_W   = 32;
    localparam int ACCEL_W   = 16;
    localparam int CNT_W     = 8;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WARMUP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ACCEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCEL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP      = 2'd3;

    localparam logic [CNT_W-1:0]   WARMUP_MIN   = 8'd3;
    localparam logic [CNT_W-1:0]   CNT_MAX      = 8'd255;
    localparam logic [CNT_W-1:0]   WARMUP_RST   = 8'd5;
    localparam logic [ACCEL_W-1:0] MIN_ACCEL_RST = 16'd1311;
    localparam logic [ACCEL_W-1:0] MAX_ACCEL_RST = 16'd13107;
    localparam logic [ACCEL_W-1:0] STEP_RST      = 16'd1311;

    typedef struct packed {
        logic [PRICE_W-1:0] bar_high;
        logic [PRICE_W-1:0] bar_low;
        logic [PRICE_W-1:0] bar_close;
        logic               series_start;
    } bar_t;

    typedef struct packed {
        logic [PRICE_W-1:0] stop_value;
        logic               trend_up;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0]   warmup_count;
        logic [ACCEL_W-1:0] min_accel;
        logic [ACCEL_W-1:0] max_accel;
        logic [ACCEL_W-1:0] accel_step;
    } cfg_t;

    // work item for the back end: seed from warmup or one tracking bar
    typedef struct packed {
        logic               is_seed;
        logic               seed_up;
        logic [PRICE_W-1:0] hi;        // bar high, or window high on seed
        logic [PRICE_W-1:0] lo;        // bar low, or window low on seed
        logic [PRICE_W-1:0] lo_floor;  // min of the two previous lows
        logic [PRICE_W-1:0] hi_ceil;   // max of the two previous highs
    } cmd_t;

endpackage

// File: src/psar_fifo.sv
// ----------------------------------------------------------------------------
// psar_fifo
// Small register queue with first-word fall-through read.
// ----------------------------------------------------------------------------
module psar_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: src/psar_front.sv
// ----------------------------------------------------------------------------
// psar_front
// Accepts bars, runs the warmup window and bar history, and issues seed and
// tracking work items to the back end.
// ----------------------------------------------------------------------------
module psar_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  psar_pkg::bar_t  bar,
    input  psar_pkg::cfg_t  cfg,
    output logic            cmd_push,
    output psar_pkg::cmd_t  cmd
);
    import psar_pkg::*;

    logic [CNT_W-1:0]   bar_count_reg, bar_count_next;
    logic [PRICE_W-1:0] first_close_reg, first_close_next;
    logic [PRICE_W-1:0] win_high_reg, win_high_next;
    logic [PRICE_W-1:0] win_low_reg, win_low_next;
    logic [PRICE_W-1:0] low1_reg, low2_reg, high1_reg, high2_reg;

    logic [CNT_W-1:0]   warm_len;
    logic [CNT_W-1:0]   bc;
    logic [PRICE_W-1:0] wh, wl, fc;
    logic               in_warmup, last_warm;

    assign warm_len = (cfg.warmup_count < WARMUP_MIN) ? WARMUP_MIN : cfg.warmup_count;

    always_comb
    begin
        // series start clears the window before this bar counts
        bc = bar.series_start ? '0 : bar_count_reg;
        wh = bar.series_start ? '0 : win_high_reg;
        wl = bar.series_start ? '1 : win_low_reg;
        fc = (bc == '0) ? bar.bar_close : first_close_reg;

        in_warmup = (bc < warm_len);
        last_warm = ({1'b0, bc} + 1'b1) == {1'b0, warm_len};

        first_close_next = first_close_reg;
        win_high_next    = win_high_reg;
        win_low_next     = win_low_reg;
        if (bar.series_start)
        begin
            win_high_next = '0;
            win_low_next  = '1;
        end
        if (in_warmup)
        begin
            first_close_next = fc;
            win_high_next    = (bar.bar_high > wh) ? bar.bar_high : wh;
            win_low_next     = (bar.bar_low < wl) ? bar.bar_low : wl;
        end
        bar_count_next = (bc < CNT_MAX) ? bc + 1'b1 : bc;

        cmd_push     = accept && (!in_warmup || last_warm);
        cmd.is_seed  = in_warmup;
        cmd.seed_up  = bar.bar_close > fc;
        cmd.hi       = in_warmup ? win_high_next : bar.bar_high;
        cmd.lo       = in_warmup ? win_low_next : bar.bar_low;
        cmd.lo_floor = (low1_reg < low2_reg) ? low1_reg : low2_reg;
        cmd.hi_ceil  = (high1_reg > high2_reg) ? high1_reg : high2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bar_count_reg   <= '0;
            first_close_reg <= '0;
            win_high_reg    <= '0;
            win_low_reg     <= '1;
            low1_reg        <= '0;
            low2_reg        <= '0;
            high1_reg       <= '0;
            high2_reg       <= '0;
        end
        else if (accept)
        begin
            bar_count_reg   <= bar_count_next;
            first_close_reg <= first_close_next;
            win_high_reg    <= win_high_next;
            win_low_reg     <= win_low_next;
            low1_reg        <= bar.bar_low;
            low2_reg        <= low1_reg;
            high1_reg       <= bar.bar_high;
            high2_reg       <= high1_reg;
        end
    end

endmodule

// File: src/psar_back.sv
// ----------------------------------------------------------------------------
// psar_back
// Holds stop, extreme point, acceleration and trend, and applies one work
// item per cycle while the result queue has room: a seed or one stop-and-reverse update.
// ----------------------------------------------------------------------------
module psar_back (
    input  logic              clk,
    input  logic              rst_n,
    input  psar_pkg::cfg_t    cfg,
    input  logic              cmd_valid,
    input  psar_pkg::cmd_t    cmd,
    output logic              cmd_pop,
    input  logic              res_full,
    output logic              res_push,
    output psar_pkg::result_t res
);
    import psar_pkg::*;

    logic [PRICE_W-1:0] stop_reg, stop_next;
    logic [PRICE_W-1:0] ext_reg, ext_next;
    logic [ACCEL_W-1:0] accel_reg, accel_next;
    logic               up_reg, up_next;

    logic                              take;
    logic signed [PRICE_W:0]           diff;
    logic signed [PRICE_W+ACCEL_W+1:0] prod;
    logic signed [PRICE_W+1:0]         step_amt;
    logic signed [PRICE_W+1:0]         moved_wide;
    logic [PRICE_W-1:0]                moved, clamped, new_ext;
    logic [ACCEL_W:0]                  accel_sum;
    logic [ACCEL_W-1:0]                grown, accel_upd;
    logic                              new_extreme, flip;

    assign take     = cmd_valid & ~res_full;
    assign cmd_pop  = take;
    assign res_push = take;

    always_comb
    begin
        diff = up_reg ? $signed({1'b0, ext_reg}) - $signed({1'b0, stop_reg})
                      : $signed({1'b0, stop_reg}) - $signed({1'b0, ext_reg});
    end

    // floor of accel * diff in Q0.16 is the arithmetic shift of the product
    assign prod     = diff * $signed({1'b0, accel_reg});
    assign step_amt = prod[PRICE_W+ACCEL_W+1:ACCEL_W];

    always_comb
    begin
        moved_wide = up_reg ? $signed({2'b00, stop_reg}) + step_amt
                            : $signed({2'b00, stop_reg}) - step_amt;
        moved      = moved_wide[PRICE_W-1:0];

        accel_sum = {1'b0, accel_reg} + {1'b0, cfg.accel_step};
        grown     = (accel_sum < {1'b0, cfg.max_accel}) ? accel_sum[ACCEL_W-1:0]
                                                        : cfg.max_accel;

        if (up_reg)
        begin
            clamped     = (moved > cmd.lo_floor) ? cmd.lo_floor : moved;
            new_extreme = ext_reg < cmd.hi;
            new_ext     = new_extreme ? cmd.hi : ext_reg;
            flip        = clamped >= cmd.lo;
        end
        else
        begin
            clamped     = (moved < cmd.hi_ceil) ? cmd.hi_ceil : moved;
            new_extreme = ext_reg > cmd.lo;
            new_ext     = new_extreme ? cmd.lo : ext_reg;
            flip        = clamped <= cmd.hi;
        end
        accel_upd = new_extreme ? grown : accel_reg;

        if (cmd.is_seed)
        begin
            up_next    = cmd.seed_up;
            stop_next  = cmd.seed_up ? cmd.lo : cmd.hi;
            ext_next   = cmd.seed_up ? cmd.hi : cmd.lo;
            accel_next = cfg.min_accel;
        end
        else if (flip)
        begin
            up_next    = ~up_reg;
            stop_next  = new_ext;
            ext_next   = up_reg ? cmd.lo : cmd.hi;
            accel_next = cfg.min_accel;
        end
        else
        begin
            up_next    = up_reg;
            stop_next  = clamped;
            ext_next   = new_ext;
            accel_next = accel_upd;
        end

        res.stop_value = stop_next;
        res.trend_up   = up_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_reg  <= '0;
            ext_reg   <= '0;
            accel_reg <= '0;
            up_reg    <= 1'b0;
        end
        else if (take)
        begin
            stop_reg  <= stop_next;
            ext_reg   <= ext_next;
            accel_reg <= accel_next;
            up_reg    <= up_next;
        end
    end

`ifndef SYNTHESIS
    // a trend flip on a tracking bar restarts the acceleration
    assert property (@(posedge clk) disable iff (!rst_n)
        take && !cmd.is_seed && (up_next != up_reg) |=> accel_reg == $past(cfg.min_accel))
        else $error("accel not restarted on trend flip");

    // a rising trend that holds keeps its stop below the bar low
    assert property (@(posedge clk) disable iff (!rst_n)
        take && !cmd.is_seed && up_reg && up_next |-> stop_next < cmd.lo)
        else $error("rising stop touches bar low without flip");

    // a falling trend that holds keeps its stop above the bar high
    assert property (@(posedge clk) disable iff (!rst_n)
        take && !cmd.is_seed && !up_reg && !up_next |-> stop_next > cmd.hi)
        else $error("falling stop touches bar high without flip");

    // state moves only when an item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(stop_reg) && $stable(up_reg) && $stable(accel_reg))
        else $error("tracker state changed without an item");
`endif

endmodule

// File: src/parabolic_sar_tracker_core.sv
// ----------------------------------------------------------------------------
// parabolic_sar_tracker_core
// Parabolic stop-and-reverse tracker, one price bar per item.
// ----------------------------------------------------------------------------
// Takes one bar per clock, sustained, as long as the result queue is drained.
// An accepted bar is written into the work queue. The back end applies it at
// the earliest once it sits there, and its result enters the result queue at
// the same edge as the back end's state update; the back end stalls while the
// result queue is full. A bar passes the work queue and result queue registers
// on its way to the result ports. Warmup bars before the last give no result.
// The rate is set by the back end's update loop (multiply, add, clamp and
// trend compare feeding the stop register). CMD_DEPTH and RES_DEPTH size the
// queue between front and back and the result queue; full rises when the work queue is full.
module parabolic_sar_tracker_core #(
    parameter int CMD_DEPTH = 4,
    parameter int RES_DEPTH = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  psar_pkg::bar_t                      bar,
    output logic                                empty,
    input  logic                                pop,
    output psar_pkg::result_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [psar_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [psar_pkg::ACCEL_W-1:0]        cfg_data
);
    import psar_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    cmd_t    cmd_in, cmd_out;
    result_t res_in;
    logic    accept, cmd_push, cmd_full, cmd_empty, cmd_pop;
    logic    res_push, res_full;

    assign cfg_ready = 1'b1;
    assign accept    = push & ~cmd_full;
    assign full      = cmd_full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_WARMUP:    cfg_next.warmup_count = cfg_data[CNT_W-1:0];
                REG_MIN_ACCEL: cfg_next.min_accel    = cfg_data;
                REG_MAX_ACCEL: cfg_next.max_accel    = cfg_data;
                REG_STEP:      cfg_next.accel_step   = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.warmup_count <= WARMUP_RST;
            cfg_reg.min_accel    <= MIN_ACCEL_RST;
            cfg_reg.max_accel    <= MAX_ACCEL_RST;
            cfg_reg.accel_step   <= STEP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    psar_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .bar      (bar),
        .cfg      (cfg_reg),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    psar_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_out),
        .empty (cmd_empty)
    );

    psar_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (~cmd_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    psar_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

// File: tb/sv/tb_parabolic_sar_tracker_core.sv
// ----------------------------------------------------------------------------
// tb_parabolic_sar_tracker_core
// Self-checking bench for the parabolic stop-and-reverse tracker. Bars go in
// through the push/full side. A model of the tracker in the bench predicts the
// stop value and the trend of every bar that gives a result. Each popped
// result is compared against the oldest prediction. Directed series cover
// extreme prices and the corner settings. Random price walks with some noise,
// and one long receiver stall, make up the rest of the run.
// ----------------------------------------------------------------------------
module tb_parabolic_sar_tracker_core;

    import psar_pkg::*;

    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 100;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              push      = 1'b0;
    logic              full;
    bar_t              bar       = '0;
    logic              empty;
    logic              pop       = 1'b0;
    result_t           result;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_WARMUP;
    logic [ACCEL_W-1:0]   cfg_data  = '0;

    bit gaps_on  = 1'b1;
    bit hold_off = 1'b0;
    int errors   = 0;
    int bars_sent = 0;
    int cycle_count = 0;

    // register copies
    logic [CNT_W-1:0]   warmup_reg    = WARMUP_RST;
    logic [ACCEL_W-1:0] accel_min_reg = MIN_ACCEL_RST;
    logic [ACCEL_W-1:0] accel_max_reg = MAX_ACCEL_RST;
    logic [ACCEL_W-1:0] accel_inc_reg = STEP_RST;

    // tracker state
    logic [CNT_W-1:0]   bars_seen  = '0;
    logic [PRICE_W-1:0] open_close = '0;
    logic [PRICE_W-1:0] win_hi     = '0;
    logic [PRICE_W-1:0] win_lo     = '1;
    logic [PRICE_W-1:0] prev_lo1   = '0;
    logic [PRICE_W-1:0] prev_lo2   = '0;
    logic [PRICE_W-1:0] prev_hi1   = '0;
    logic [PRICE_W-1:0] prev_hi2   = '0;
    logic [PRICE_W-1:0] sar        = '0;
    logic [PRICE_W-1:0] ep         = '0;
    logic [ACCEL_W-1:0] af         = '0;
    logic               up         = 1'b0;

    result_t sar_expected[$];

    longint walk_level;
    int unsigned walk_swing;

    parabolic_sar_tracker_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .bar       (bar),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(negedge clk)
        pop <= !hold_off && (!gaps_on || $urandom_range(99) >= 28);

    function automatic logic [ACCEL_W-1:0] grown_af();
        logic [ACCEL_W:0] sum;
        sum = {1'b0, af} + {1'b0, accel_inc_reg};
        return (sum < {1'b0, accel_max_reg}) ? sum[ACCEL_W-1:0] : accel_max_reg;
    endfunction

    // advance the tracker by one bar, queue the result if the bar gives one
    function automatic void sar_predict_bar(bar_t b);
        int      w;
        longint  v;
        bit      emits;
        result_t item;
        w = (warmup_reg < WARMUP_MIN) ? int'(WARMUP_MIN) : int'(warmup_reg);
        emits = 1'b0;
        if (b.series_start)
        begin
            bars_seen = '0;
            win_hi = '0;
            win_lo = '1;
        end
        if (bars_seen < w)
        begin
            if (bars_seen == 0)
                open_close = b.bar_close;
            if (b.bar_high > win_hi)
                win_hi = b.bar_high;
            if (b.bar_low < win_lo)
                win_lo = b.bar_low;
            if (int'(bars_seen) + 1 == w)
            begin
                up = b.bar_close > open_close;
                sar = up ? win_lo : win_hi;
                ep = up ? win_hi : win_lo;
                af = accel_min_reg;
                emits = 1'b1;
            end
        end
        else
        begin
            if (up)
            begin
                v = longint'(sar) + ((longint'(af) * (longint'(ep) - longint'(sar))) >>> ACCEL_W);
                if (v > longint'(prev_lo2))
                    v = longint'(prev_lo2);
                if (v > longint'(prev_lo1))
                    v = longint'(prev_lo1);
                if (ep < b.bar_high)
                begin
                    ep = b.bar_high;
                    af = grown_af();
                end
                // a negative stop counts as touched
                if (v < 0 || v >= longint'(b.bar_low))
                begin
                    up = 1'b0;
                    af = accel_min_reg;
                    sar = ep;
                    ep = b.bar_low;
                end
                else
                    sar = v[PRICE_W-1:0];
            end
            else
            begin
                v = longint'(sar) - ((longint'(af) * (longint'(sar) - longint'(ep))) >>> ACCEL_W);
                if (v < longint'(prev_hi2))
                    v = longint'(prev_hi2);
                if (v < longint'(prev_hi1))
                    v = longint'(prev_hi1);
                sar = v[PRICE_W-1:0];
                if (ep > b.bar_low)
                begin
                    ep = b.bar_low;
                    af = grown_af();
                end
                if (sar <= b.bar_high)
                begin
                    up = 1'b1;
                    af = accel_min_reg;
                    sar = ep;
                    ep = b.bar_high;
                end
            end
            emits = 1'b1;
        end
        prev_lo2 = prev_lo1;
        prev_lo1 = b.bar_low;
        prev_hi2 = prev_hi1;
        prev_hi1 = b.bar_high;
        if (bars_seen < CNT_MAX)
            bars_seen++;
        if (emits)
        begin
            item.stop_value = sar;
            item.trend_up   = up;
            sar_expected.insert(sar_expected.size(), item);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [PRICE_W-1:0] got,
                                   input logic [PRICE_W-1:0] want);
        $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (sar_expected.size() == 0)
                report_mismatch("result with none expected", result.stop_value, '0);
            else
            begin
                want = sar_expected.pop_front();
                if (result.stop_value !== want.stop_value)
                    report_mismatch("stop_value", result.stop_value, want.stop_value);
                if (result.trend_up !== want.trend_up)
                    report_mismatch("trend_up", 32'(result.trend_up), 32'(want.trend_up));
            end
        end
    end

    // called and returns at a falling edge
    task automatic send_bar(input bar_t b);
        if (gaps_on)
            while ($urandom_range(99) < 28)
            begin
                push = 1'b0;
                @(negedge clk);
            end
        push = 1'b1;
        bar = b;
        do
            @(posedge clk);
        while (full);
        sar_predict_bar(b);
        bars_sent++;
        @(negedge clk);
        push = 1'b0;
    endtask

    // bars left in the block may still be warmup bars with no result
    task automatic wait_idle();
        while (sar_expected.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ACCEL_W-1:0] data);
        wait_idle();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_WARMUP:    warmup_reg = data[CNT_W-1:0];
            REG_MIN_ACCEL: accel_min_reg = data;
            REG_MAX_ACCEL: accel_max_reg = data;
            REG_STEP:      accel_inc_reg = data;
            default:       ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_config(input logic [CNT_W-1:0] w, input logic [ACCEL_W-1:0] amin,
                              input logic [ACCEL_W-1:0] amax, input logic [ACCEL_W-1:0] astep);
        // upper data bits are don't-care for the warmup register
        write_reg(REG_WARMUP, {8'($urandom_range(255)), w});
        write_reg(REG_MIN_ACCEL, amin);
        write_reg(REG_MAX_ACCEL, amax);
        write_reg(REG_STEP, astep);
    endtask

    function automatic bar_t mk_bar(input logic [PRICE_W-1:0] hi, input logic [PRICE_W-1:0] lo,
                                    input logic [PRICE_W-1:0] cl, input logic st);
        return '{bar_high: hi, bar_low: lo, bar_close: cl, series_start: st};
    endfunction

    function automatic longint clamp_price(input longint p);
        if (p < 0)
            return 0;
        if (p > longint'(32'hFFFF_FFFF))
            return longint'(32'hFFFF_FFFF);
        return p;
    endfunction

    function automatic bar_t walk_bar();
        longint hi;
        longint lo;
        walk_level = clamp_price(walk_level + longint'($urandom_range(2 * walk_swing))
                                 - longint'(walk_swing));
        hi = clamp_price(walk_level + longint'($urandom_range(walk_swing)));
        lo = clamp_price(walk_level - longint'($urandom_range(walk_swing)));
        return mk_bar(hi[31:0], lo[31:0], lo[31:0] + $urandom_range(32'(hi - lo)), 1'b0);
    endfunction

    // price walk; noise_pct of the bars are fully random
    task automatic send_walk(input int n, input bit restart, input int noise_pct);
        bar_t b;
        if (restart)
        begin
            walk_level = longint'($urandom);
            case ($urandom_range(3))
                0:       walk_swing = $urandom_range(1, 200);
                1:       walk_swing = $urandom_range(1000, 1000000);
                2:       walk_swing = $urandom_range(1 << 20, 1 << 28);
                default: walk_swing = $urandom_range(50, 5000);
            endcase
        end
        for (int i = 0; i < n; i++)
        begin
            if (i > 0 && $urandom_range(99) < noise_pct)
                b = mk_bar($urandom, $urandom, $urandom, $urandom_range(15) == 0);
            else
            begin
                b = walk_bar();
                b.series_start = restart && i == 0;
            end
            send_bar(b);
        end
    endtask

    // first bar after reset counts as bar one without a series start
    task automatic test_no_series_start();
        send_bar(mk_bar(32'd100, 32'd90, 32'd95, 1'b0));
        send_bar(mk_bar(32'd0, 32'd0, 32'd0, 1'b0));
        send_bar(mk_bar(32'd120, 32'd80, 32'd110, 1'b0));
        send_bar(mk_bar(32'd130, 32'd100, 32'd125, 1'b0));
        send_bar(mk_bar(32'd140, 32'd120, 32'd135, 1'b0));
        send_bar(mk_bar(32'd150, 32'd130, 32'd145, 1'b0));
        send_bar(mk_bar(32'd90, 32'd60, 32'd70, 1'b0));
    endtask

    task automatic test_price_extremes();
        set_config(8'd0, 16'd0, 16'hFFFF, 16'hFFFF);
        send_bar(mk_bar('1, '0, '0, 1'b1));
        send_bar(mk_bar('0, '1, '1, 1'b0));
        send_bar(mk_bar('1, '1, '1, 1'b0));
        send_bar(mk_bar('0, '0, '0, 1'b0));
        send_bar(mk_bar('1, '0, '1, 1'b0));
        send_bar(mk_bar(32'h8000_0000, 32'h7FFF_FFFF, '0, 1'b0));
        // low above high
        send_bar(mk_bar(32'd5, 32'd10, 32'd7, 1'b0));
        send_bar(mk_bar('1, '1, '0, 1'b0));
        send_bar(mk_bar('0, '0, '0, 1'b0));
        send_bar(mk_bar(32'd1, 32'd0, 32'd1, 1'b0));
        send_bar(mk_bar(32'hFFFF_FFFE, 32'd1, 32'h5555_5555, 1'b0));
        send_bar(mk_bar(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0));
    endtask

    task automatic test_config_corners();
        // zero acceleration
        set_config(8'd3, 16'd0, 16'd0, 16'd1);
        send_walk(25, 1'b1, 0);
        // full-scale acceleration, warmup below the floor
        set_config(8'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_walk(25, 1'b1, 0);
        // min above max
        set_config(8'd4, 16'd20000, 16'd1000, 16'd500);
        send_walk(25, 1'b1, 0);
        // factor never grows
        set_config(8'd5, 16'd1311, 16'd13107, 16'd0);
        send_walk(25, 1'b1, 0);
        set_config(8'd1, 16'd1000, 16'd60000, 16'hFFFF);
        send_walk(25, 1'b1, 0);
        // longest warmup
        set_config(8'd255, 16'd2000, 16'd20000, 16'd2000);
        send_walk(260, 1'b1, 0);
    endtask

    // tracking bars pick up whatever state the short warmup left behind
    task automatic test_warmup_mid_series();
        set_config(8'd10, 16'd1311, 16'd13107, 16'd1311);
        send_walk(6, 1'b1, 0);
        write_reg(REG_WARMUP, {8'($urandom_range(255)), 8'd4});
        send_walk(20, 1'b0, 0);
        write_reg(REG_WARMUP, {8'($urandom_range(255)), 8'd0});
        send_walk(10, 1'b0, 0);
    endtask

    task automatic test_result_backpressure();
        set_config(8'd3, 16'd1311, 16'd13107, 16'd1311);
        fork
            begin
                hold_off = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off = 1'b0;
            end
            send_walk(60, 1'b1, 0);
        join
    endtask

    task automatic test_random_series();
        int target;
        logic [CNT_W-1:0]   w;
        logic [ACCEL_W-1:0] amin;
        logic [ACCEL_W-1:0] amax;
        logic [ACCEL_W-1:0] astep;
        for (int phase = 0; phase < 8; phase++)
        begin
            case ($urandom_range(9))
                0:       w = 8'($urandom_range(2));
                1:       w = 8'($urandom_range(9, 40));
                default: w = 8'($urandom_range(3, 8));
            endcase
            if ($urandom_range(3) == 0)
            begin
                amin = 16'($urandom);
                amax = 16'($urandom);
                astep = 16'($urandom);
            end
            else
            begin
                amin = 16'($urandom_range(4000));
                amax = amin + 16'($urandom_range(30000));
                astep = 16'($urandom_range(1, 3000));
            end
            set_config(w, amin, amax, astep);
            // one phase runs with no gaps on either side
            gaps_on = phase != 3;
            target = bars_sent + 120;
            while (bars_sent < target)
                send_walk(int'(w) + $urandom_range(1, 40), 1'b1, 15);
            gaps_on = 1'b1;
        end
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_no_series_start();
        test_price_extremes();
        test_config_corners();
        test_warmup_mid_series();
        test_result_backpressure();
        test_random_series();
        wait_idle();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: parabolic_sar_tracker_core.f
src/psar_pkg.sv
src/psar_fifo.sv
src/psar_front.sv
src/psar_back.sv
src/parabolic_sar_tracker_core.sv
tb/sv/tb_parabolic_sar_tracker_core.sv
